@@ hw/rtl/efd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

  localparam int NumSlots = 5;
  localparam int SlotIdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // command codes
  localparam logic [2:0] KIND_CREATE   = 3'd0;
  localparam logic [2:0] KIND_DELETE   = 3'd1;
  localparam logic [2:0] KIND_SEND     = 3'd2;
  localparam logic [2:0] KIND_CLEAR    = 3'd3;
  localparam logic [2:0] KIND_DISPATCH = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_IDLE  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  task_slot;
    logic [7:0]  event_bits;
    logic [15:0] handler_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_out;
    logic [7:0]  pending_out;
    logic [15:0] handler_out;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply it to the slot table and load the result register
  } dp_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/efd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module efd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output efd_pkg::dp_ctrl_t dp_ctrl
);
  import efd_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd_ready      = 1'b0;
    dp_ctrl        = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          dp_ctrl.load = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register must be free (or emptying) before we overwrite it
        if (!rsp_valid || rsp_ready) begin
          dp_ctrl.exec   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state == S_EXEC))
    else $error("accepted item did not enter execute");

  a_exec_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && rsp_valid && !rsp_ready) |=> (state == S_EXEC && rsp_valid))
    else $error("execute overran a pending result");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && (!rsp_valid || rsp_ready)) |=> (state == S_IDLE && rsp_valid))
    else $error("execute finished without a result");

endmodule

`default_nettype wire

@@ hw/rtl/efd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module efd_dp (
  input  logic              clk,
  input  logic              rst,
  input  efd_pkg::dp_ctrl_t dp_ctrl,
  input  efd_pkg::cmd_t     cmd,
  output efd_pkg::rsp_t     rsp
);
  import efd_pkg::*;

  cmd_t                cmd_q;
  rsp_t                rsp_q;
  rsp_t                rsp_next;
  logic [15:0]         handler [NumSlots];
  logic [7:0]          events  [NumSlots];
  logic [15:0]         handler_next [NumSlots];
  logic [7:0]          events_next  [NumSlots];
  logic [SlotIdxW-1:0] scan_ptr;
  logic [SlotIdxW-1:0] scan_ptr_next;
  logic [SlotIdxW-1:0] cur_slot;
  logic [SlotIdxW-1:0] cur_slot_next;

  logic                free_found;
  logic [SlotIdxW-1:0] free_idx;
  logic                hi_found;
  logic [SlotIdxW-1:0] hi_idx;
  logic                lo_found;
  logic [SlotIdxW-1:0] lo_idx;
  logic                disp_found;
  logic [SlotIdxW-1:0] disp_idx;
  logic                slot_ok;
  logic [SlotIdxW-1:0] tgt;

  // lowest free slot, and round-robin pick of a ready slot from scan_ptr on
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hi_found   = 1'b0;
    hi_idx     = '0;
    lo_found   = 1'b0;
    lo_idx     = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (handler[i] == '0) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
      if (handler[i] != '0 && events[i] != '0) begin
        lo_found = 1'b1;
        lo_idx   = SlotIdxW'(i);
        if (i >= int'(scan_ptr)) begin
          hi_found = 1'b1;
          hi_idx   = SlotIdxW'(i);
        end
      end
    end
    disp_found = hi_found || lo_found;
    disp_idx   = hi_found ? hi_idx : lo_idx;
  end

  assign slot_ok = int'(cmd_q.task_slot) < NumSlots;
  assign tgt     = SlotIdxW'(cmd_q.task_slot);

  always_comb begin
    handler_next  = handler;
    events_next   = events;
    scan_ptr_next = scan_ptr;
    cur_slot_next = cur_slot;
    rsp_next      = '0;
    rsp_next.status = STATUS_OK;
    case (cmd_q.kind)
      KIND_CREATE: begin
        if (free_found) begin
          handler_next[free_idx] = cmd_q.handler_id;
          events_next[free_idx]  = '0;
          rsp_next.slot_out      = 3'(free_idx);
        end else begin
          rsp_next.status = STATUS_FULL;
        end
      end
      KIND_DELETE: begin
        if (slot_ok) begin
          handler_next[tgt] = '0;
          events_next[tgt]  = '0;
        end else begin
          rsp_next.status = STATUS_RANGE;
        end
      end
      KIND_SEND: begin
        if (slot_ok) begin
          events_next[tgt] = events[tgt] | cmd_q.event_bits;
        end else begin
          rsp_next.status = STATUS_RANGE;
        end
      end
      KIND_CLEAR: begin
        // acts on the last dispatched slot even if it was deleted since
        if (int'(cur_slot) < NumSlots) begin
          events_next[cur_slot] = events[cur_slot] & ~cmd_q.event_bits;
        end
      end
      KIND_DISPATCH: begin
        if (disp_found) begin
          cur_slot_next        = disp_idx;
          scan_ptr_next        = (int'(disp_idx) + 1 < NumSlots) ?
                                 SlotIdxW'(int'(disp_idx) + 1) : '0;
          rsp_next.slot_out    = 3'(disp_idx);
          rsp_next.pending_out = events[disp_idx];
          rsp_next.handler_out = handler[disp_idx];
        end else begin
          rsp_next.status = STATUS_IDLE;
        end
      end
      default: rsp_next.status = STATUS_RANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumSlots; i++) begin
        handler[i] <= '0;
        events[i]  <= '0;
      end
      scan_ptr <= '0;
      cur_slot <= '0;
    end else if (dp_ctrl.exec) begin
      handler  <= handler_next;
      events   <= events_next;
      scan_ptr <= scan_ptr_next;
      cur_slot <= cur_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctrl.load) begin
      cmd_q <= cmd;
    end
    if (dp_ctrl.exec) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp = rsp_q;

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (int'(scan_ptr) < NumSlots) && (int'(cur_slot) < NumSlots))
    else $error("scan or current slot pointer out of range");

endmodule

`default_nettype wire

@@ hw/rtl/event_flag_task_dispatcher.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Event-flag task dispatcher. Keeps a table of efd_pkg::NumSlots task slots,
// each a 16-bit handler id (0 = free) and an 8-bit pending-event mask. Every
// item on cmd is one command (create, delete, send, clear, dispatch) and gives
// exactly one item on rsp with a status code. Dispatch picks, round-robin from
// the slot after the last one dispatched, the first slot with a handler and
// pending events; the events are left set, so software clears them with a
// clear command, which always acts on the last dispatched slot. Each item is
// first captured in the command register, then executed on the slot table
// and written to the result register; the whole slot scan is combinational,
// done in that execute step. The block handles one item at a time, and it
// takes the next item while the previous result still sits in the result
// register; execution of that next item waits only until the result is taken.
// All slots are free and both pointers are zero after reset.
module event_flag_task_dispatcher (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  efd_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output efd_pkg::rsp_t rsp
);
  import efd_pkg::*;

  dp_ctrl_t dp_ctrl;

  // sequencing: capture, execute, result handshake
  efd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .dp_ctrl   (dp_ctrl)
  );

  // slot table, pointers, command and result registers
  efd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .dp_ctrl (dp_ctrl),
    .cmd     (cmd),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import efd_pkg::*;

  // kind values with no command behind them
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 925;
  localparam int TailItems   = 100;  // last stretch of the run runs without idling
  localparam int DrainCycles = 8;

  logic  clk;
  logic  rst;
  logic  cmd_valid;
  logic  cmd_ready;
  cmd_t  cmd;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  event_flag_task_dispatcher dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Slot table mirror: handler ids, pending masks, scan pointer, current slot
  // ---------------------------------------------------------------------------
  logic [15:0] task_hnd [NumSlots] = '{default: 16'h0000};
  logic [7:0]  task_evt [NumSlots] = '{default: 8'h00};
  int          scan_ptr = 0;
  int          cur_slot = 0;

  // Applies one command to the mirror and returns the result it should give.
  function automatic rsp_t run_cmd(cmd_t c);
    rsp_t r;
    int   hit;
    int   p;
    r   = '0;
    hit = -1;
    case (c.kind)
      KIND_CREATE: begin
        // lowest free slot; a zero handler leaves the slot free
        for (int i = 0; i < NumSlots; i++)
          if (hit < 0 && task_hnd[i] == 16'h0000) hit = i;
        if (hit < 0) begin
          r.status = STATUS_FULL;
        end else begin
          task_hnd[hit] = c.handler_id;
          task_evt[hit] = 8'h00;
          r.status      = STATUS_OK;
          r.slot_out    = 3'(hit);
        end
      end
      KIND_DELETE: begin
        if (c.task_slot >= NumSlots) begin
          r.status = STATUS_RANGE;
        end else begin
          task_hnd[c.task_slot] = 16'h0000;
          task_evt[c.task_slot] = 8'h00;
          r.status = STATUS_OK;
        end
      end
      KIND_SEND: begin
        if (c.task_slot >= NumSlots) begin
          r.status = STATUS_RANGE;
        end else begin
          task_evt[c.task_slot] = task_evt[c.task_slot] | c.event_bits;
          r.status = STATUS_OK;
        end
      end
      KIND_CLEAR: begin
        // hits the last dispatched slot even when it was deleted since
        task_evt[cur_slot] = task_evt[cur_slot] & ~c.event_bits;
        r.status = STATUS_OK;
      end
      KIND_DISPATCH: begin
        p = scan_ptr;
        for (int i = 0; i < NumSlots; i++) begin
          if (hit < 0 && task_hnd[p] != 16'h0000 && task_evt[p] != 8'h00) hit = p;
          p = (p + 1 < NumSlots) ? p + 1 : 0;
        end
        if (hit < 0) begin
          r.status = STATUS_IDLE;
        end else begin
          cur_slot      = hit;
          scan_ptr      = (hit + 1 < NumSlots) ? hit + 1 : 0;
          r.status      = STATUS_OK;
          r.slot_out    = 3'(hit);
          r.pending_out = task_evt[hit];
          r.handler_out = task_hnd[hit];
        end
      end
      default: r.status = STATUS_RANGE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Expectation is pushed when the command is taken, and
  // popped when a result is taken.
  // ---------------------------------------------------------------------------
  rsp_t due_q [$];
  rsp_t next_due;
  rsp_t want;
  bit   cur_typed;     // current item carries a hand-typed result
  rsp_t cur_typed_rsp;
  int   err_cnt = 0;
  int   items_sent;
  int   rsp_seen = 0;
  int   st_cnt [4] = '{default: 0};
  int   cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        next_due = run_cmd(cmd);
        if (cur_typed) next_due = cur_typed_rsp;
        due_q.push_back(next_due);
      end
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (due_q.size() == 0) begin
          $error("result with nothing expected: status %0d slot %0d", rsp.status, rsp.slot_out);
          err_cnt++;
        end else begin
          want = due_q.pop_front();
          st_cnt[want.status]++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_cnt++;
          end
          if (rsp.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, got %0d", want.slot_out, rsp.slot_out);
            err_cnt++;
          end
          if (rsp.pending_out !== want.pending_out) begin
            $error("pending_out: expected %h, got %h", want.pending_out, rsp.pending_out);
            err_cnt++;
          end
          if (rsp.handler_out !== want.handler_out) begin
            $error("handler_out: expected %h, got %h", want.handler_out, rsp.handler_out);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles, due_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side backpressure: random stall bursts between runs of ready;
  // held high whenever no_idle is set.
  // ---------------------------------------------------------------------------
  bit no_idle;
  int hold_left = 0;

  always @(negedge clk) begin
    if (no_idle) begin
      rsp_ready = 1'b1;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if ($urandom_range(2) == 0) begin
      rsp_ready = 1'b0;
      hold_left = $urandom_range(0, 15);
    end else begin
      rsp_ready = 1'b1;
      hold_left = $urandom_range(0, 31);
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  cmd_t dir_cmd_q [$];
  bit   dir_typed_q [$];
  rsp_t dir_rsp_q [$];

  task automatic add_row(input cmd_t c, input bit typed, input rsp_t r);
    dir_cmd_q.push_back(c);
    dir_typed_q.push_back(typed);
    dir_rsp_q.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input cmd_t c, input bit typed, input rsp_t r);
    if (!no_idle && $urandom_range(3) == 0) begin
      cmd_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    cmd           = c;
    cur_typed     = typed;
    cur_typed_rsp = r;
    cmd_valid     = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Random command of the given kind; slot mostly in range, masks and ids
  // lean toward their extremes now and then.
  function automatic cmd_t rand_cmd(input logic [2:0] k);
    cmd_t        c;
    logic [2:0]  s;
    logic [7:0]  e;
    logic [15:0] h;
    if ($urandom_range(9) == 0) s = 3'($urandom_range(NumSlots, 7));
    else s = 3'($urandom_range(0, NumSlots - 1));
    case ($urandom_range(7))
      0:       e = 8'h00;
      1:       e = 8'hFF;
      default: e = 8'($urandom);
    endcase
    case ($urandom_range(9))
      0:       h = 16'h0000;
      1:       h = 16'hFFFF;
      default: h = 16'($urandom);
    endcase
    c = {k, s, e, h};
    return c;
  endfunction

  function automatic logic [2:0] rand_kind();
    int r;
    r = $urandom_range(99);
    if (r < 20) return KIND_CREATE;
    if (r < 34) return KIND_DELETE;
    if (r < 58) return KIND_SEND;
    if (r < 74) return KIND_CLEAR;
    if (r < 96) return KIND_DISPATCH;
    return 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
  endfunction

  int rnd_done;

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cur_typed = 1'b0;
    cur_typed_rsp = '0;
    no_idle   = 1'b0;
    items_sent = 0;

    // Directed table. Rows with a typed result are checked against it;
    // the rest against the mirror.
    // empty table: dispatch goes idle, clear on slot 0 is harmless
    add_row({KIND_DISPATCH, 3'd0, 8'h00, 16'h0000}, 1'b1, {STATUS_IDLE, 3'd0, 8'h00, 16'h0000});
    add_row({KIND_CLEAR, 3'd0, 8'hFF, 16'h0000}, 1'b1, {STATUS_OK, 3'd0, 8'h00, 16'h0000});
    // out of range slot and unused kinds
    add_row({KIND_SEND, 3'd7, 8'hFF, 16'hFFFF}, 1'b1, {STATUS_RANGE, 3'd0, 8'h00, 16'h0000});
    add_row({KIND_DELETE, 3'd5, 8'h00, 16'h0000}, 1'b1, {STATUS_RANGE, 3'd0, 8'h00, 16'h0000});
    add_row({KIND_UNUSED_LO, 3'd0, 8'h00, 16'h0000}, 1'b1, {STATUS_RANGE, 3'd0, 8'h00, 16'h0000});
    add_row({KIND_UNUSED_HI, 3'd7, 8'hFF, 16'hFFFF}, 1'b1, {STATUS_RANGE, 3'd0, 8'h00, 16'h0000});
    // fill the table; a zero handler leaves its slot free for the next create
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'hFFFF}, 1'b1, {STATUS_OK, 3'd0, 8'h00, 16'h0000});
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'h0001}, 1'b1, {STATUS_OK, 3'd1, 8'h00, 16'h0000});
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'h0000}, 1'b1, {STATUS_OK, 3'd2, 8'h00, 16'h0000});
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'h8000}, 1'b1, {STATUS_OK, 3'd2, 8'h00, 16'h0000});
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'hA5A5}, 1'b1, {STATUS_OK, 3'd3, 8'h00, 16'h0000});
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'h5A5A}, 1'b1, {STATUS_OK, 3'd4, 8'h00, 16'h0000});
    add_row({KIND_CREATE, 3'd0, 8'h00, 16'h1234}, 1'b1, {STATUS_FULL, 3'd0, 8'h00, 16'h0000});
    // post events, then walk the round robin including the wrap
    add_row({KIND_SEND, 3'd0, 8'hFF, 16'h0000}, 1'b1, {STATUS_OK, 3'd0, 8'h00, 16'h0000});
    add_row({KIND_SEND, 3'd4, 8'h01, 16'h0000}, 1'b0, '0);
    add_row({KIND_SEND, 3'd1, 8'h80, 16'h0000}, 1'b0, '0);
    add_row({KIND_DISPATCH, 3'd0, 8'h00, 16'h0000}, 1'b1, {STATUS_OK, 3'd0, 8'hFF, 16'hFFFF});
    add_row({KIND_CLEAR, 3'd0, 8'h0F, 16'h0000}, 1'b0, '0);
    add_row({KIND_DISPATCH, 3'd0, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({KIND_DISPATCH, 3'd0, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({KIND_DISPATCH, 3'd0, 8'h00, 16'h0000}, 1'b0, '0);
    // delete the current task, clear it anyway, post to the now free slot
    add_row({KIND_DELETE, 3'd0, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({KIND_CLEAR, 3'd0, 8'hFF, 16'h0000}, 1'b0, '0);
    add_row({KIND_SEND, 3'd0, 8'h55, 16'h0000}, 1'b0, '0);
    add_row({KIND_DISPATCH, 3'd0, 8'h00, 16'h0000}, 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < dir_cmd_q.size(); i++)
      send_item(dir_cmd_q[i], dir_typed_q[i], dir_rsp_q[i]);

    // Random part. A third of the steps are a service pair (dispatch, then
    // clear some of the dispatched events), the rest single commands.
    rnd_done = 0;
    while (rnd_done < RandomItems) begin
      if (rnd_done >= RandomItems - TailItems) no_idle = 1'b1;
      else if (rnd_done % 150 == 0) no_idle = ($urandom_range(3) == 0);
      if ($urandom_range(2) == 0) begin
        send_item(rand_cmd(KIND_DISPATCH), 1'b0, '0);
        send_item(rand_cmd(KIND_CLEAR), 1'b0, '0);
        rnd_done += 2;
      end else begin
        send_item(rand_cmd(rand_kind()), 1'b0, '0);
        rnd_done++;
      end
    end
    cmd_valid = 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("tb: %0d commands sent, %0d results checked in %0d cycles", items_sent, rsp_seen,
             cycles);
    $display("tb: results ok %0d, out of range %0d, table full %0d, dispatch idle %0d",
             st_cnt[STATUS_OK], st_cnt[STATUS_RANGE], st_cnt[STATUS_FULL], st_cnt[STATUS_IDLE]);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/efd_pkg.sv
hw/rtl/efd_ctrl.sv
hw/rtl/efd_dp.sv
hw/rtl/event_flag_task_dispatcher.sv
tb/tb.sv
